/* design/dps_pkg.sv */
package dps_pkg;

	typedef enum logic [2:0] {
		KIND_ADMIT   = 3'd0,
		KIND_SET_ST  = 3'd1,
		KIND_TICK    = 3'd2,
		KIND_PICK    = 3'd3,
		KIND_SET_PRI = 3'd4
	} dps_kind_t;

	typedef enum logic [2:0] {
		ST_UNUSED   = 3'd0,
		ST_USED     = 3'd1,
		ST_SLEEPING = 3'd2,
		ST_RUNNABLE = 3'd3,
		ST_RUNNING  = 3'd4,
		ST_ZOMBIE   = 3'd5
	} dps_state_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_RD,
		FSM_EV,
		FSM_DIV,
		FSM_WR,
		FSM_PWR,
		FSM_DONE
	} dps_fsm_t;

	localparam logic [6:0] PRI_MAX     = 7'd100;
	localparam logic [6:0] PRI_DEFAULT = 7'd60;
	localparam logic [3:0] NICE_NEUTRAL = 4'd5;

	typedef struct packed {
		logic [2:0]  state;
		logic [15:0] id;
		logic [6:0]  spri;
		logic [6:0]  dpri;
		logic [31:0] run_ticks;
		logic [31:0] sleep_ticks;
		logic [31:0] run_count;
		logic [31:0] create_time;
	} dps_row_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

endpackage

/* design/dps_if.sv */
interface dps_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [5:0]  slot;
	logic [2:0]  new_state;
	logic [15:0] target_pid;
	logic [6:0]  new_priority;

	modport source (output valid, kind, slot, new_state, target_pid, new_priority, input ready);
	modport sink (input valid, kind, slot, new_state, target_pid, new_priority, output ready);
endinterface

interface dps_out_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [5:0]  result_slot;
	logic [15:0] result_pid;
	logic [6:0]  old_priority;
	logic        reschedule;

	modport source (output valid, ok, result_slot, result_pid, old_priority, reschedule,
		input ready);
	modport sink (input valid, ok, result_slot, result_pid, old_priority, reschedule,
		output ready);
endinterface

/* design/dynamic_priority_task_scheduler.sv */
// Dynamic priority task scheduler.
// Requests enter on req (valid/ready); one result beat per request leaves on rsp.
// A request is taken only while the block is idle; it then sweeps the task
// table held in a single-port-write RAM, one slot at a time.
// Work per request, for SLOTS table entries:
//   set state             : read of the named slot, then its write
//   admit, set priority   : read and check each slot up to the hit, write at the hit
//   pick                  : read of every slot, then a write of the winner if any
//   tick                  : per slot: read, four restoring divide steps, write
// The per-slot cost of a tick is set by the shared 4-step niceness divider.
// cfg_we/cfg_wdata load the default static priority; write it only when idle.
// Reset clears every table valid bit (an entry not yet written reads as zero),
// the tick counter, sets the next id to one and forgets the last pick.
// The result sits in an output register; a stalled receiver holds the block
// in its final state until the beat is taken.
module dynamic_priority_task_scheduler #(
	parameter int SLOTS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	dps_in_if.sink     req,
	dps_out_if.source  rsp
);
	import dps_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int RW = $bits(dps_row_t);
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	dps_fsm_t state_q, state_nxt;

	logic [6:0]    def_q;
	logic [31:0]   tick_q;
	logic [15:0]   next_id_q;
	logic [16:0]   last_pick_q;
	logic [SLOTS-1:0] vld_q;

	dps_kind_t     kind_q;
	logic [5:0]    slot_q;
	logic [2:0]    nst_q;
	logic [15:0]   tpid_q;
	logic [6:0]    npri_q;
	logic [IW-1:0] idx_q;

	dps_row_t      row_q;
	dps_row_t      best_q;
	logic [IW-1:0] bslot_q;
	logic          found_q;

	logic        res_ok_q;
	logic [5:0]  res_slot_q;
	logic [15:0] res_pid_q;
	logic [6:0]  res_old_q;
	logic        res_rs_q;

	logic        ov_q;
	logic        o_ok_q;
	logic [5:0]  o_slot_q;
	logic [15:0] o_pid_q;
	logic [6:0]  o_old_q;
	logic        o_rs_q;

	logic          ram_we, ram_re;
	logic [IW-1:0] ram_waddr, ram_raddr;
	dps_row_t      ram_wdata;
	logic [RW-1:0] ram_rdata;

	dps_row_t row, upd, adm, wr_tick, pwr;
	logic     accept, is_last, hit_admit, hit_pri, take_best, keep_best;
	logic     div_start, div_done;
	logic [3:0] nice;
	logic [8:0] dsum;
	logic [6:0] dyn;
	logic [6:0] npri_cl;
	logic       arg_ok;

	dps_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	dps_nice_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (div_start),
		.sleep_ticks (upd.sleep_ticks),
		.run_ticks   (upd.run_ticks),
		.done        (div_done),
		.nice        (nice)
	);

	assign accept  = req.valid && req.ready;
	assign is_last = (idx_q == LAST);
	assign arg_ok  = (9'(req.slot) < 9'(SLOTS)) && (req.new_state <= ST_ZOMBIE);

	// row as seen by the sweep: never-written entries read as zero
	always_comb begin
		row = vld_q[idx_q] ? dps_row_t'(ram_rdata) : '0;

		upd = row;
		if (row.state == ST_RUNNING) begin
			upd.run_ticks = sat_inc(row.run_ticks);
		end
		if (row.state == ST_SLEEPING) begin
			upd.sleep_ticks = sat_inc(row.sleep_ticks);
		end

		adm             = '0;
		adm.state       = ST_USED;
		adm.id          = next_id_q;
		adm.spri        = def_q;
		adm.dpri        = (next_id_q == 16'd1 || next_id_q == 16'd2) ? 7'd1 : def_q;
		adm.create_time = tick_q;

		dsum = 9'(row_q.spri) + 9'(NICE_NEUTRAL) - 9'(nice);
		if (dsum[8]) begin
			dyn = 7'd0;
		end else if (dsum > 9'(PRI_MAX)) begin
			dyn = PRI_MAX;
		end else begin
			dyn = dsum[6:0];
		end
		wr_tick      = row_q;
		wr_tick.dpri = dyn;

		pwr       = best_q;
		pwr.state = ST_RUNNING;
		if (last_pick_q != {1'b0, best_q.id}) begin
			pwr.run_count = sat_inc(best_q.run_count);
		end

		npri_cl   = (npri_q > PRI_MAX) ? PRI_MAX : npri_q;
		hit_admit = (row.state == ST_UNUSED);
		hit_pri   = (row.state != ST_UNUSED) && (row.id == tpid_q);
		keep_best = (best_q.dpri < row.dpri)
			|| (best_q.dpri == row.dpri && best_q.run_count < row.run_count)
			|| (best_q.dpri == row.dpri && best_q.run_count == row.run_count
				&& best_q.create_time <= row.create_time);
		take_best = (row.state == ST_RUNNABLE) && (!found_q || !keep_best);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and RAM / divider control
	always_comb begin
		state_nxt = state_q;
		req.ready = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = row;
		div_start = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					case (dps_kind_t'(req.kind))
						KIND_ADMIT, KIND_TICK, KIND_PICK, KIND_SET_PRI: state_nxt = FSM_RD;
						KIND_SET_ST: state_nxt = arg_ok ? FSM_RD : FSM_DONE;
						default: state_nxt = FSM_DONE;
					endcase
				end
			end
			FSM_RD: begin
				ram_re    = 1'b1;
				state_nxt = FSM_EV;
			end
			FSM_EV: begin
				case (kind_q)
					KIND_ADMIT: begin
						if (hit_admit) begin
							ram_we    = 1'b1;
							ram_wdata = adm;
							state_nxt = FSM_DONE;
						end else begin
							state_nxt = is_last ? FSM_DONE : FSM_RD;
						end
					end
					KIND_SET_ST: begin
						ram_we          = 1'b1;
						ram_wdata       = row;
						ram_wdata.state = nst_q;
						state_nxt       = FSM_DONE;
					end
					KIND_TICK: begin
						div_start = 1'b1;
						state_nxt = FSM_DIV;
					end
					KIND_PICK: begin
						if (is_last) begin
							state_nxt = (found_q || take_best) ? FSM_PWR : FSM_DONE;
						end else begin
							state_nxt = FSM_RD;
						end
					end
					KIND_SET_PRI: begin
						if (hit_pri) begin
							ram_we         = 1'b1;
							ram_wdata      = row;
							ram_wdata.spri = npri_q;
							ram_wdata.dpri = npri_cl;
							state_nxt      = FSM_DONE;
						end else begin
							state_nxt = is_last ? FSM_DONE : FSM_RD;
						end
					end
					default: state_nxt = FSM_DONE;
				endcase
			end
			FSM_DIV: begin
				if (div_done) begin
					state_nxt = FSM_WR;
				end
			end
			FSM_WR: begin
				ram_we    = 1'b1;
				ram_wdata = wr_tick;
				state_nxt = is_last ? FSM_DONE : FSM_RD;
			end
			FSM_PWR: begin
				ram_we    = 1'b1;
				ram_waddr = bslot_q;
				ram_wdata = pwr;
				state_nxt = FSM_DONE;
			end
			FSM_DONE: begin
				if (!ov_q || rsp.ready) begin
					state_nxt = FSM_IDLE;
				end
			end
			default: state_nxt = FSM_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_q       <= PRI_DEFAULT;
			tick_q      <= '0;
			next_id_q   <= 16'd1;
			last_pick_q <= '1;
			vld_q       <= '0;
			ov_q        <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				def_q <= cfg_wdata;
			end
			if (accept) begin
				found_q <= 1'b0;
				if (dps_kind_t'(req.kind) == KIND_TICK) begin
					tick_q <= sat_inc(tick_q);
				end
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (state_q == FSM_EV && kind_q == KIND_ADMIT && hit_admit) begin
				next_id_q <= next_id_q + 16'd1;
			end
			if (state_q == FSM_EV && kind_q == KIND_PICK && take_best) begin
				found_q <= 1'b1;
			end
			if (state_q == FSM_PWR && last_pick_q != {1'b0, best_q.id}) begin
				last_pick_q <= {1'b0, best_q.id};
			end
			if (state_q == FSM_DONE && (!ov_q || rsp.ready)) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// sweep index, item fields and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q     <= dps_kind_t'(req.kind);
			slot_q     <= req.slot;
			nst_q      <= req.new_state;
			tpid_q     <= req.target_pid;
			npri_q     <= req.new_priority;
			idx_q      <= (dps_kind_t'(req.kind) == KIND_SET_ST) ? IW'(req.slot) : '0;
			res_ok_q   <= (dps_kind_t'(req.kind) == KIND_TICK);
			res_slot_q <= '0;
			res_pid_q  <= '0;
			res_old_q  <= '0;
			res_rs_q   <= 1'b0;
		end
		if (state_q == FSM_EV) begin
			row_q <= upd;
			case (kind_q)
				KIND_ADMIT: begin
					if (hit_admit) begin
						res_ok_q   <= 1'b1;
						res_slot_q <= 6'(idx_q);
						res_pid_q  <= next_id_q;
					end
				end
				KIND_SET_ST: begin
					res_ok_q   <= 1'b1;
					res_slot_q <= slot_q;
				end
				KIND_PICK: begin
					if (take_best) begin
						best_q  <= row;
						bslot_q <= idx_q;
					end
				end
				KIND_SET_PRI: begin
					if (hit_pri) begin
						res_ok_q   <= 1'b1;
						res_slot_q <= 6'(idx_q);
						res_old_q  <= row.spri;
						res_rs_q   <= (npri_cl < row.spri);
					end
				end
				default: ;
			endcase
			if (kind_q != KIND_TICK && !is_last) begin
				idx_q <= idx_q + IW'(1);
			end
		end
		if (state_q == FSM_WR && !is_last) begin
			idx_q <= idx_q + IW'(1);
		end
		if (state_q == FSM_PWR) begin
			res_ok_q   <= 1'b1;
			res_slot_q <= 6'(bslot_q);
			res_pid_q  <= best_q.id;
		end
		if (state_q == FSM_DONE && (!ov_q || rsp.ready)) begin
			o_ok_q   <= res_ok_q;
			o_slot_q <= res_slot_q;
			o_pid_q  <= res_pid_q;
			o_old_q  <= res_old_q;
			o_rs_q   <= res_rs_q;
		end
	end

	assign rsp.valid        = ov_q;
	assign rsp.ok           = o_ok_q;
	assign rsp.result_slot  = o_slot_q;
	assign rsp.result_pid   = o_pid_q;
	assign rsp.old_priority = o_old_q;
	assign rsp.reschedule   = o_rs_q;
endmodule

/* design/dps_ram.sv */
module dps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* design/dps_nice_div.sv */
module dps_nice_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] sleep_ticks,
	input  logic [31:0] run_ticks,
	output logic        done,
	output logic [3:0]  nice
);
	import dps_pkg::*;

	logic        busy_q;
	logic        zero_q;
	logic [1:0]  step_q;
	logic [35:0] num_q;
	logic [32:0] den_q;
	logic [3:0]  q_q;
	logic [32:0] den_start;
	logic [35:0] den_sh;

	assign den_start = {1'b0, sleep_ticks} + {1'b0, run_ticks};
	assign den_sh    = 36'(den_q) << step_q;
	assign done      = busy_q && (step_q == 2'd0);
	assign nice      = q_q;

	// control: one restoring step per cycle, quotient bit 3 down to 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
			zero_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			zero_q <= (den_start == '0);
			step_q <= (den_start == '0) ? 2'd0 : 2'd3;
		end else if (busy_q) begin
			if (step_q == 2'd0) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q - 2'd1;
			end
		end
	end

	// datapath: shared subtract and compare
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= (36'(sleep_ticks) << 3) + (36'(sleep_ticks) << 1);
			den_q <= den_start;
			q_q   <= (den_start == '0) ? NICE_NEUTRAL : 4'd0;
		end else if (busy_q && !zero_q && (num_q >= den_sh)) begin
			num_q         <= num_q - den_sh;
			q_q[step_q]   <= 1'b1;
		end
	end
endmodule

/* design/dps_checker.sv */
module dps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        ok,
	input logic [15:0] result_pid,
	input logic [6:0]  old_priority,
	input logic        reschedule
);
	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// drop ready for the cycle after a request is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// a failed request reports nothing else
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> result_pid == 16'd0 && old_priority == 7'd0 && !reschedule)
		else $error("failed result carries payload");

	// reschedule only comes with a match
	a_resched_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reschedule |-> ok)
		else $error("reschedule without match");
endmodule

bind dynamic_priority_task_scheduler dps_checker u_dps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (req.valid),
	.in_ready     (req.ready),
	.out_valid    (rsp.valid),
	.out_ready    (rsp.ready),
	.ok           (rsp.ok),
	.result_pid   (rsp.result_pid),
	.old_priority (rsp.old_priority),
	.reschedule   (rsp.reschedule)
);

/* tb/tb_dynamic_priority_task_scheduler.sv */
`timescale 1ns / 1ps

module tb_dynamic_priority_task_scheduler;
	import dps_pkg::*;

	localparam int NSLOT = 64;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [2:0]  kind;
		logic [5:0]  slot;
		logic [2:0]  new_state;
		logic [15:0] target_pid;
		logic [6:0]  new_priority;
	} sched_req_t;

	typedef struct {
		logic        ok;
		logic [5:0]  result_slot;
		logic [15:0] result_pid;
		logic [6:0]  old_priority;
		logic        reschedule;
	} sched_rsp_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [6:0] cfg_wdata;

	dps_in_if  req_if();
	dps_out_if rsp_if();

	dynamic_priority_task_scheduler #(.SLOTS(NSLOT)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_if),
		.rsp      (rsp_if)
	);

	sched_req_t pending_reqs[$];
	sched_rsp_t expected_rsps[$];
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_send;
	bit req_taken;
	int mismatches;
	int cycles;

	// shadow task table
	logic [2:0]  m_state[NSLOT];
	logic [15:0] m_id[NSLOT];
	logic [6:0]  m_spri[NSLOT];
	logic [6:0]  m_dpri[NSLOT];
	logic [31:0] m_run_ticks[NSLOT];
	logic [31:0] m_sleep_ticks[NSLOT];
	logic [31:0] m_run_count[NSLOT];
	logic [31:0] m_create[NSLOT];
	logic [31:0] m_tick_count;
	logic [15:0] m_next_id;
	logic [16:0] m_last_pick;
	logic [6:0]  m_default_pri;

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic logic [6:0] niceness_pri(input int i);
		longint unsigned s;
		longint unsigned r;
		int nice;
		int d;
		s = m_sleep_ticks[i];
		r = m_run_ticks[i];
		if (s + r == 0)
			nice = 5;
		else
			nice = int'((10 * s) / (s + r));
		d = int'(m_spri[i]) - nice + 5;
		if (d < 0)
			d = 0;
		if (d > 100)
			d = 100;
		return d[6:0];
	endfunction

	// true when entry a ranks ahead of entry b
	function automatic bit ranks_ahead(input int a, input int b);
		if (m_dpri[a] != m_dpri[b])
			return m_dpri[a] < m_dpri[b];
		if (m_run_count[a] != m_run_count[b])
			return m_run_count[a] < m_run_count[b];
		return m_create[a] <= m_create[b];
	endfunction

	task automatic clear_table();
		for (int i = 0; i < NSLOT; i++) begin
			m_state[i] = ST_UNUSED;
			m_id[i] = '0;
			m_spri[i] = '0;
			m_dpri[i] = '0;
			m_run_ticks[i] = '0;
			m_sleep_ticks[i] = '0;
			m_run_count[i] = '0;
			m_create[i] = '0;
		end
		m_tick_count = '0;
		m_next_id = 16'd1;
		m_last_pick = '1;
		m_default_pri = 7'd60;
	endtask

	// apply one request to the shadow table and return the expected beat
	task automatic schedule_step(input sched_req_t q, output sched_rsp_t e);
		bit found;
		int best;
		logic [6:0] old;
		e = '{ok: 1'b0, result_slot: '0, result_pid: '0, old_priority: '0, reschedule: 1'b0};
		found = 0;
		best = 0;
		case (q.kind)
			KIND_ADMIT: begin
				for (int i = 0; i < NSLOT && !found; i++) begin
					if (m_state[i] == ST_UNUSED) begin
						found = 1;
						m_state[i] = ST_USED;
						m_id[i] = m_next_id;
						m_next_id = m_next_id + 16'd1;
						m_spri[i] = m_default_pri;
						m_dpri[i] = (m_id[i] == 16'd1 || m_id[i] == 16'd2) ? 7'd1 : m_default_pri;
						m_run_ticks[i] = '0;
						m_sleep_ticks[i] = '0;
						m_run_count[i] = '0;
						m_create[i] = m_tick_count;
						e.ok = 1'b1;
						e.result_slot = i[5:0];
						e.result_pid = m_id[i];
					end
				end
			end
			KIND_SET_ST: begin
				if (q.new_state <= 3'd5) begin
					m_state[q.slot] = q.new_state;
					e.ok = 1'b1;
					e.result_slot = q.slot;
				end
			end
			KIND_TICK: begin
				m_tick_count = bump(m_tick_count);
				for (int i = 0; i < NSLOT; i++) begin
					if (m_state[i] == ST_RUNNING)
						m_run_ticks[i] = bump(m_run_ticks[i]);
					if (m_state[i] == ST_SLEEPING)
						m_sleep_ticks[i] = bump(m_sleep_ticks[i]);
					m_dpri[i] = niceness_pri(i);
				end
				e.ok = 1'b1;
			end
			KIND_PICK: begin
				for (int i = 0; i < NSLOT; i++) begin
					if (m_state[i] == ST_RUNNABLE) begin
						if (!found || !ranks_ahead(best, i))
							best = i;
						found = 1;
					end
				end
				if (found) begin
					if (m_last_pick != {1'b0, m_id[best]}) begin
						m_run_count[best] = bump(m_run_count[best]);
						m_last_pick = {1'b0, m_id[best]};
					end
					m_state[best] = ST_RUNNING;
					e.ok = 1'b1;
					e.result_slot = best[5:0];
					e.result_pid = m_id[best];
				end
			end
			KIND_SET_PRI: begin
				for (int i = 0; i < NSLOT && !found; i++) begin
					if (m_state[i] != ST_UNUSED && m_id[i] == q.target_pid) begin
						found = 1;
						old = m_spri[i];
						m_spri[i] = q.new_priority;
						m_dpri[i] = (q.new_priority > 7'd100) ? 7'd100 : q.new_priority;
						e.ok = 1'b1;
						e.result_slot = i[5:0];
						e.old_priority = old;
						e.reschedule = m_dpri[i] < old;
					end
				end
			end
			default: ;
		endcase
	endtask

	function automatic void queue_req(input logic [2:0] k, input logic [5:0] s,
		input logic [2:0] st, input logic [15:0] pid, input logic [6:0] pri);
		sched_req_t q;
		q.kind = k;
		q.slot = s;
		q.new_state = st;
		q.target_pid = pid;
		q.new_priority = pri;
		pending_reqs.push_back(q);
	endfunction

	// random request, mostly well-formed traffic on a small set of slots and ids
	function automatic void queue_random(input bit admit_heavy);
		int r;
		logic [5:0] s;
		logic [2:0] st;
		logic [15:0] pid;
		r = $urandom_range(99);
		s = ($urandom_range(99) < 70) ? 6'($urandom_range(15)) : 6'($urandom_range(63));
		r = admit_heavy ? r / 2 : r;
		if ($urandom_range(99) < 40)
			st = ST_RUNNABLE;
		else if ($urandom_range(99) < 10)
			st = 3'($urandom_range(6, 7));
		else
			st = 3'($urandom_range(5));
		pid = ($urandom_range(99) < 80) ? 16'($urandom_range(90)) : 16'($urandom);
		if (r < 25)
			queue_req(KIND_ADMIT, 6'($urandom), 3'($urandom), 16'($urandom), 7'($urandom));
		else if (r < 50)
			queue_req(KIND_SET_ST, s, st, 16'($urandom), 7'($urandom));
		else if (r < 60)
			queue_req(KIND_TICK, 6'($urandom), 3'($urandom), 16'($urandom), 7'($urandom));
		else if (r < 80)
			queue_req(KIND_PICK, 6'($urandom), 3'($urandom), 16'($urandom), 7'($urandom));
		else if (r < 95)
			queue_req(KIND_SET_PRI, s, st, pid, 7'($urandom));
		else
			queue_req(3'($urandom_range(5, 7)), 6'($urandom), 3'($urandom), 16'($urandom),
				7'($urandom));
	endfunction

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0);
	endtask

	task automatic write_default_pri(input logic [6:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		m_default_pri = v;
	endtask

	task automatic run_random(input int n, input bit admit_heavy);
		for (int i = 0; i < n; i++)
			queue_random(admit_heavy);
		// pause the sender midway until everything in flight is back
		while (pending_reqs.size() > n / 2)
			@(negedge clk);
		hold_send = 1;
		do
			@(negedge clk);
		while (req_if.valid || expected_rsps.size() != 0);
		hold_send = 0;
		wait_drained();
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// driver: present request beats at the falling edge
	always @(posedge clk)
		req_taken <= req_if.valid && req_if.ready;

	always @(negedge clk) begin
		sched_req_t q;
		if (arst_n) begin
			if (!req_if.valid || req_taken) begin
				if (pending_reqs.size() != 0 && !hold_send
					&& $urandom_range(99) >= send_idle_pct) begin
					q = pending_reqs.pop_front();
					req_if.valid <= 1'b1;
					req_if.kind <= q.kind;
					req_if.slot <= q.slot;
					req_if.new_state <= q.new_state;
					req_if.target_pid <= q.target_pid;
					req_if.new_priority <= q.new_priority;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
			rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// predict on each accepted request beat
	always @(posedge clk) begin
		sched_req_t q;
		sched_rsp_t e;
		if (arst_n && req_if.valid && req_if.ready) begin
			q.kind = req_if.kind;
			q.slot = req_if.slot;
			q.new_state = req_if.new_state;
			q.target_pid = req_if.target_pid;
			q.new_priority = req_if.new_priority;
			schedule_step(q, e);
			expected_rsps.push_back(e);
		end
	end

	// monitor: compare each result beat with the oldest expectation
	always @(posedge clk) begin
		sched_rsp_t e;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: ok=%0b slot=%0d pid=%0d",
						rsp_if.ok, rsp_if.result_slot, rsp_if.result_pid);
			end else begin
				e = expected_rsps.pop_front();
				if (rsp_if.ok !== e.ok || rsp_if.result_slot !== e.result_slot
					|| rsp_if.result_pid !== e.result_pid
					|| rsp_if.old_priority !== e.old_priority
					|| rsp_if.reschedule !== e.reschedule) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: exp ok=%0b slot=%0d pid=%0d old=%0d rs=%0b,",
							e.ok, e.result_slot, e.result_pid, e.old_priority, e.reschedule,
							" got ok=%0b slot=%0d pid=%0d old=%0d rs=%0b",
							rsp_if.ok, rsp_if.result_slot, rsp_if.result_pid,
							rsp_if.old_priority, rsp_if.reschedule);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_if.valid = 1'b0;
		req_if.kind = '0;
		req_if.slot = '0;
		req_if.new_state = '0;
		req_if.target_pid = '0;
		req_if.new_priority = '0;
		rsp_if.ready = 1'b0;
		req_taken = 1'b0;
		hold_send = 0;
		mismatches = 0;
		cycles = 0;
		send_idle_pct = 18;
		recv_idle_pct = 52;
		clear_table();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed: ids one and two, tie breaks, ignored codes, clamps, misses
		queue_req(KIND_PICK, 0, 0, 0, 0);
		queue_req(KIND_ADMIT, 0, 0, 0, 0);
		queue_req(KIND_ADMIT, 0, 0, 0, 0);
		queue_req(KIND_ADMIT, 0, 0, 0, 0);
		queue_req(KIND_SET_ST, 0, ST_RUNNABLE, 0, 0);
		queue_req(KIND_SET_ST, 1, ST_RUNNABLE, 0, 0);
		queue_req(KIND_SET_ST, 2, ST_SLEEPING, 0, 0);
		queue_req(KIND_SET_ST, 63, ST_ZOMBIE, 0, 0);
		queue_req(KIND_SET_ST, 3, 3'd6, 0, 0);
		queue_req(KIND_SET_ST, 3, 3'd7, 0, 0);
		queue_req(KIND_PICK, 0, 0, 0, 0);
		queue_req(KIND_PICK, 0, 0, 0, 0);
		queue_req(KIND_TICK, 0, 0, 0, 0);
		queue_req(KIND_SET_ST, 0, ST_RUNNABLE, 0, 0);
		queue_req(KIND_PICK, 0, 0, 0, 0);
		queue_req(KIND_SET_PRI, 0, 0, 16'd3, 7'd127);
		queue_req(KIND_SET_PRI, 0, 0, 16'hFFFF, 7'd0);
		queue_req(KIND_SET_PRI, 0, 0, 16'd1, 7'd0);
		queue_req(3'd5, 6'h3F, 3'd7, 16'hFFFF, 7'h7F);
		queue_req(3'd6, 0, 0, 0, 0);
		queue_req(3'd7, 0, 0, 0, 0);
		queue_req(KIND_SET_ST, 63, ST_UNUSED, 0, 0);
		queue_req(KIND_TICK, 0, 0, 0, 0);
		queue_req(KIND_PICK, 0, 0, 0, 0);
		wait_drained();

		write_default_pri(7'd100);
		run_random(130, 0);

		send_idle_pct = 52;
		recv_idle_pct = 18;
		write_default_pri(7'd0);
		run_random(130, 1);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_default_pri(7'($urandom_range(100)));
		run_random(130, 0);

		repeat (1000) @(negedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
